@@ rtl/stsrk_pkg.sv @@
// Shared types and constants of the stiff string RK4 step block.
// No dependencies; imported by the controller, the datapath and the top level.
package stsrk_pkg;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_STEP  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_RESP
	} state_t;

	localparam logic [2:0] CFG_WAVE  = 3'd0;
	localparam logic [2:0] CFG_STIFF = 3'd1;
	localparam logic [2:0] CFG_DAMP  = 3'd2;
	localparam logic [2:0] CFG_STEP  = 3'd3;

	localparam logic [1:0] STAGE_FIRST = 2'd0;
	localparam logic [1:0] STAGE_LAST  = 2'd3;

	// Drain span from a sweep's last read issue to its final store write.
	localparam int DRAIN_LEN = 6;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       issue;
		logic       clear_we;
		logic       accept;
		logic       resp;
		logic       load_out;
		logic       clear_flag;
		logic [1:0] stage;
	} cmd_t;

endpackage

@@ rtl/stsrk_ctrl.sv @@
// Controller state machine of the stiff string RK4 step block.
// Depends on stsrk_pkg; drives the datapath through cmd_t and a sweep address.
module stsrk_ctrl import stsrk_pkg::*; #(
	parameter int POINTS = 256,
	localparam int AW = $clog2(POINTS)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [1:0]  action,
	input  logic        out_stall,
	output logic        in_stall,
	output logic        out_valid,
	output cmd_t        cmd,
	output logic [AW:0] addr
);

	state_t      state_q, state_d;
	logic [AW:0] cnt_q, cnt_d;
	logic [1:0]  stage_q, stage_d;
	logic [2:0]  drain_q, drain_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		stage_d = stage_q;
		drain_d = drain_q;
		unique case (state_q)
			ST_CLEAR: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == (AW+1)'(POINTS - 1)) begin
					state_d = ST_IDLE;
					cnt_d   = '0;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (action_t'(action) == ACT_STEP) begin
						state_d = ST_SWEEP;
						stage_d = STAGE_FIRST;
						cnt_d   = '0;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_SWEEP: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == (AW+1)'(POINTS)) begin
					state_d = ST_DRAIN;
					drain_d = '0;
				end
			end
			ST_DRAIN: begin
				drain_d = drain_q + 1'b1;
				if (drain_q == 3'(DRAIN_LEN - 1)) begin
					if (stage_q == STAGE_LAST) begin
						state_d = ST_RESP;
					end else begin
						state_d = ST_SWEEP;
						stage_d = stage_q + 1'b1;
						cnt_d   = '0;
					end
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.stage      = stage_q;
		in_stall       = 1'b1;
		unique case (state_q)
			ST_CLEAR: cmd.clear_we = 1'b1;
			ST_IDLE: begin
				in_stall       = 1'b0;
				cmd.accept     = in_valid;
				cmd.clear_flag = in_valid && (action_t'(action) == ACT_STEP);
			end
			ST_SWEEP: cmd.issue = 1'b1;
			ST_DRAIN: ;
			ST_RESP: begin
				cmd.resp     = 1'b1;
				cmd.load_out = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			stage_q     <= STAGE_FIRST;
			drain_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			stage_q <= stage_d;
			drain_q <= drain_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign addr      = cnt_q;
	assign out_valid = out_valid_q;

endmodule

@@ rtl/stsrk_dp.sv @@
// Datapath of the stiff string RK4 step block: string memories, stencil
// window, coefficient multipliers, stage accumulation and final update.
// Depends on stsrk_pkg; commanded by stsrk_ctrl.
module stsrk_dp import stsrk_pkg::*; #(
	parameter int POINTS = 256,
	localparam int AW = $clog2(POINTS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [AW:0]        addr,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic [1:0]         action,
	input  logic [7:0]         point_index,
	input  logic signed [31:0] write_value,
	output logic signed [31:0] read_value,
	output logic               saturated
);

	localparam logic signed [47:0] MAX32 = 48'sd2147483647;
	localparam logic signed [47:0] MIN32 = -48'sd2147483648;
	localparam logic [31:0] RECIP6 = 32'hAAAAAAAB;

	typedef struct packed {
		logic [AW-1:0]      n;
		logic signed [31:0] sd;
		logic signed [31:0] sv;
		logic signed [31:0] smd;
		logic signed [31:0] smv;
	} carry_t;

	function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
		if (x > MAX32) return 32'sh7FFFFFFF;
		if (x < MIN32) return 32'sh80000000;
		return x[31:0];
	endfunction

	function automatic logic ovf32(input logic signed [47:0] x);
		return (x > MAX32) || (x < MIN32);
	endfunction

	// Q8.24 product reduction, round half up.
	function automatic logic signed [39:0] rnd24(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = p + 64'sd8388608;
		return t[63:24];
	endfunction

	// Configuration registers.
	logic [30:0] wave_q, stiff_q, damp_q, tstep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q  <= 31'd67108864;
			stiff_q <= 31'd16777;
			damp_q  <= 31'd1677722;
			tstep_q <= 31'd1678;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WAVE:  wave_q  <= cfg_data;
				CFG_STIFF: stiff_q <= cfg_data;
				CFG_DAMP:  damp_q  <= cfg_data;
				CFG_STEP:  tstep_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Memories.
	logic signed [31:0] sd_mem  [POINTS];
	logic signed [31:0] sv_mem  [POINTS];
	logic signed [31:0] td_mem  [POINTS];
	logic signed [31:0] tv_mem  [POINTS];
	logic signed [31:0] smd_mem [POINTS];
	logic signed [31:0] smv_mem [POINTS];

	logic [AW-1:0] ra, ca, pa, pb;
	logic [AW:0]   cen_full;
	logic [AW+7:0] idx_w;
	logic          pin_range, pin_inner;

	assign ra        = addr[AW-1:0];
	assign cen_full  = addr - (AW+1)'(2);
	assign ca        = cen_full[AW-1:0];
	assign idx_w     = {{AW{1'b0}}, point_index};
	assign pin_range = idx_w < (AW+8)'(POINTS);
	assign pin_inner = (idx_w >= (AW+8)'(1)) && (idx_w < (AW+8)'(POINTS - 1));
	assign pa        = idx_w[AW-1:0];
	assign pb        = cmd.accept ? pa : ca;

	// Pipeline registers.
	logic signed [31:0] sdA_s1, svA_s1, tdA_s1, tvA_s1, sdB_s1, svB_s1, smd_s1, smv_s1;
	logic               amask_s1, valid_s1;
	logic [AW-1:0]      n_s1;
	logic signed [31:0] yw_q [4];
	logic signed [31:0] vw_q [4];
	logic signed [31:0] y4, v4;

	logic signed [31:0] d2y_s2, d4y_s2, d2v_s2, vc_s2;
	carry_t             c_s2, c_s3, c_s4;
	logic               valid_s2, valid_s3, valid_s4;
	logic signed [63:0] pw_s3, ps_s3, pd_s3, pt_s3;
	logic signed [31:0] kv_s4, ky_s4;

	logic signed [31:0] fin_d_s5, fin_v_s5, sd_s5, sv_s5;
	logic [AW-1:0]      n_s5, n_s6;
	logic               valid_s5, valid_s6;
	logic [63:0]        pq_d_s6, pq_v_s6;
	logic               neg_d_s6, neg_v_s6;
	logic signed [31:0] sd_s6, sv_s6;

	logic flag_q;

	// Sweep window: the newest entry comes straight from the read register.
	assign y4 = amask_s1 ? ((cmd.stage == STAGE_FIRST) ? sdA_s1 : tdA_s1) : 32'sd0;
	assign v4 = amask_s1 ? ((cmd.stage == STAGE_FIRST) ? svA_s1 : tvA_s1) : 32'sd0;

	// Stage 2: differences.
	logic signed [47:0] d2y_w, d4y_w, d2v_w;
	logic               f2;
	always_comb begin
		d2y_w = 48'(yw_q[3]) - (48'(yw_q[2]) <<< 1) + 48'(yw_q[1]);
		d4y_w = 48'(y4) - (48'(yw_q[3]) <<< 2) + 48'(yw_q[2]) * 48'sd6
			- (48'(yw_q[1]) <<< 2) + 48'(yw_q[0]);
		d2v_w = 48'(vw_q[3]) - (48'(vw_q[2]) <<< 1) + 48'(vw_q[1]);
		f2    = valid_s1 && (ovf32(d2y_w) || ovf32(d4y_w) || ovf32(d2v_w));
	end

	// Stage 4: acceleration and displacement increments.
	logic signed [39:0] mw, ms, md, mt;
	logic signed [47:0] acc;
	logic               f4;
	always_comb begin
		mw  = rnd24(pw_s3);
		ms  = rnd24(ps_s3);
		md  = rnd24(pd_s3);
		mt  = rnd24(pt_s3);
		acc = 48'(mw) - 48'(ms) + 48'(md);
		f4  = valid_s3 && (ovf32(acc) || ovf32(48'(mt)));
	end

	// Stage 5: increment sums and next trial values.
	logic signed [47:0] sumd_w, sumv_w, trd_w, trv_w;
	logic signed [31:0] hd, hv;
	logic               f5;
	always_comb begin
		hd = (cmd.stage < 2'd2) ? (ky_s4 >>> 1) : ky_s4;
		hv = (cmd.stage < 2'd2) ? (kv_s4 >>> 1) : kv_s4;
		unique case (cmd.stage)
			STAGE_FIRST: begin
				sumd_w = 48'(ky_s4);
				sumv_w = 48'(kv_s4);
			end
			2'd1, 2'd2: begin
				sumd_w = 48'(c_s4.smd) + (48'(ky_s4) <<< 1);
				sumv_w = 48'(c_s4.smv) + (48'(kv_s4) <<< 1);
			end
			default: begin
				sumd_w = 48'(c_s4.smd) + 48'(ky_s4);
				sumv_w = 48'(c_s4.smv) + 48'(kv_s4);
			end
		endcase
		trd_w = 48'(c_s4.sd) + 48'(hd);
		trv_w = 48'(c_s4.sv) + 48'(hv);
		f5 = valid_s4 && (ovf32(sumd_w) || ovf32(sumv_w) ||
			((cmd.stage != STAGE_LAST) && (ovf32(trd_w) || ovf32(trv_w))));
	end

	// Stage 6 operands: magnitude plus three for round-half-away division by six.
	logic [31:0] magd, magv;
	assign magd = (fin_d_s5[31] ? (32'd0 - 32'(fin_d_s5)) : 32'(fin_d_s5)) + 32'd3;
	assign magv = (fin_v_s5[31] ? (32'd0 - 32'(fin_v_s5)) : 32'(fin_v_s5)) + 32'd3;

	// Stage 7: final store update.
	logic signed [47:0] qd, qv, nd_w, nv_w;
	logic               f7;
	always_comb begin
		qd   = $signed(48'(pq_d_s6[63:34]));
		qv   = $signed(48'(pq_v_s6[63:34]));
		if (neg_d_s6) qd = -qd;
		if (neg_v_s6) qv = -qv;
		nd_w = 48'(sd_s6) + qd;
		nv_w = 48'(sv_s6) + qv;
		f7   = valid_s6 && (ovf32(nd_w) || ovf32(nv_w));
	end

	// Memory ports.
	always_ff @(posedge clk) begin
		sdA_s1 <= sd_mem[ra];
		svA_s1 <= sv_mem[ra];
		tdA_s1 <= td_mem[ra];
		tvA_s1 <= tv_mem[ra];
		smd_s1 <= smd_mem[ca];
		smv_s1 <= smv_mem[ca];
		if (!cmd.resp) begin
			sdB_s1 <= sd_mem[pb];
			svB_s1 <= sv_mem[pb];
		end
		priority if (cmd.clear_we) begin
			sd_mem[ra] <= 32'sd0;
			sv_mem[ra] <= 32'sd0;
		end else if (cmd.accept && (action_t'(action) == ACT_WRITE) && pin_inner) begin
			sd_mem[pa] <= write_value;
			sv_mem[pa] <= 32'sd0;
		end else if (valid_s6) begin
			sd_mem[n_s6] <= sat32(nd_w);
			sv_mem[n_s6] <= sat32(nv_w);
		end
		if (valid_s4 && (cmd.stage != STAGE_LAST)) begin
			td_mem[c_s4.n]  <= sat32(trd_w);
			tv_mem[c_s4.n]  <= sat32(trv_w);
			smd_mem[c_s4.n] <= sat32(sumd_w);
			smv_mem[c_s4.n] <= sat32(sumv_w);
		end
	end

	// Payload pipeline.
	always_ff @(posedge clk) begin
		n_s1 <= ca;
		if (cmd.issue && (addr == '0)) begin
			for (int i = 0; i < 4; i++) begin
				yw_q[i] <= 32'sd0;
				vw_q[i] <= 32'sd0;
			end
		end else begin
			yw_q[3] <= y4;
			yw_q[2] <= yw_q[3];
			yw_q[1] <= yw_q[2];
			yw_q[0] <= yw_q[1];
			vw_q[3] <= v4;
			vw_q[2] <= vw_q[3];
			vw_q[1] <= vw_q[2];
			vw_q[0] <= vw_q[1];
		end

		d2y_s2 <= sat32(d2y_w);
		d4y_s2 <= sat32(d4y_w);
		d2v_s2 <= sat32(d2v_w);
		vc_s2  <= vw_q[2];
		c_s2   <= '{n: n_s1, sd: sdB_s1, sv: svB_s1, smd: smd_s1, smv: smv_s1};

		pw_s3 <= d2y_s2 * $signed({1'b0, wave_q});
		ps_s3 <= d4y_s2 * $signed({1'b0, stiff_q});
		pd_s3 <= d2v_s2 * $signed({1'b0, damp_q});
		pt_s3 <= vc_s2 * $signed({1'b0, tstep_q});
		c_s3  <= c_s2;

		kv_s4 <= sat32(acc);
		ky_s4 <= sat32(48'(mt));
		c_s4  <= c_s3;

		fin_d_s5 <= sat32(sumd_w);
		fin_v_s5 <= sat32(sumv_w);
		sd_s5    <= c_s4.sd;
		sv_s5    <= c_s4.sv;
		n_s5     <= c_s4.n;

		pq_d_s6  <= 64'(magd) * 64'(RECIP6);
		pq_v_s6  <= 64'(magv) * 64'(RECIP6);
		neg_d_s6 <= fin_d_s5[31];
		neg_v_s6 <= fin_v_s5[31];
		sd_s6    <= sd_s5;
		sv_s6    <= sv_s5;
		n_s6     <= n_s5;
	end

	// Control pipeline, request latch and result register.
	action_t            act_q;
	logic               range_q;
	logic signed [31:0] read_value_q;
	logic               sat_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amask_s1     <= 1'b0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			valid_s4     <= 1'b0;
			valid_s5     <= 1'b0;
			valid_s6     <= 1'b0;
			flag_q       <= 1'b0;
			act_q        <= ACT_NONE;
			range_q      <= 1'b0;
			read_value_q <= 32'sd0;
			sat_out_q    <= 1'b0;
		end else begin
			amask_s1 <= cmd.issue && (addr != '0) && (addr < (AW+1)'(POINTS - 1));
			valid_s1 <= cmd.issue && (addr >= (AW+1)'(3)) && (addr <= (AW+1)'(POINTS));
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4 && (cmd.stage == STAGE_LAST);
			valid_s6 <= valid_s5;
			if (cmd.clear_flag) begin
				flag_q <= 1'b0;
			end else begin
				flag_q <= flag_q | f2 | f4 | f5 | f7;
			end
			if (cmd.accept) begin
				act_q   <= action_t'(action);
				range_q <= pin_range;
			end
			if (cmd.load_out) begin
				read_value_q <= ((act_q == ACT_READ) && range_q) ? sdB_s1 : 32'sd0;
				sat_out_q    <= flag_q;
			end
		end
	end

	assign read_value = read_value_q;
	assign saturated  = sat_out_q;

endmodule

@@ rtl/stiff_string_rk4_step_top.sv @@
// Stiff string RK4 step block, top level: controller and datapath.
// Depends on stsrk_pkg, stsrk_ctrl and stsrk_dp.
//
// The block keeps displacement and velocity of a string sampled at POINTS
// grid points, both ends pinned at zero, in signed Q8.24. Each request
// carries an action: write sets one interior displacement and clears its
// velocity, read returns one displacement, step advances the string by one
// classical RK4 time step with saturating arithmetic. Every request gives
// exactly one result holding read_value (zero unless a read in range) and
// saturated, which tells whether the most recent step clipped any value.
// After reset the block runs a clearing pass over the string memories,
// during which in_stall stays high. In a step, each of the four RK4
// stages sweeps the memories one point per cycle through a five-point
// stencil window, then drains a six-deep pipeline of differences,
// coefficient multipliers and increment sums; the final store update
// rides along with the fourth sweep. A new request is taken only once the
// previous one has finished; a result waiting in the output register does
// not hold up the next request until a second result is ready. The user
// must write configuration through cfg_we only while the block is idle;
// the block itself does not enforce this.
module stiff_string_rk4_step_top import stsrk_pkg::*; #(
	parameter int POINTS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [7:0]         point_index,
	input  logic signed [31:0] write_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] read_value,
	output logic               saturated,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data
);

	localparam int AW = $clog2(POINTS);

	// Command bundle and sweep address from the controller.
	cmd_t        cmd;
	logic [AW:0] addr;

	stsrk_ctrl #(.POINTS(POINTS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.action    (action),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd),
		.addr      (addr)
	);

	stsrk_dp #(.POINTS(POINTS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.addr        (addr),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.action      (action),
		.point_index (point_index),
		.write_value (write_value),
		.read_value  (read_value),
		.saturated   (saturated)
	);

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for stiff_string_rk4_step_top: writes, reads and RK4 steps.
// Depends on stsrk_pkg and the block's RTL; holds its own string predictor.
module testbench;
	import stsrk_pkg::*;

	localparam int N_PTS = 256;

	typedef struct {
		logic signed [31:0] value;
		logic               clipped;
	} reply_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	action_t            action;
	logic [7:0]         point_index;
	logic signed [31:0] write_value;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] read_value;
	logic               saturated;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [30:0]        cfg_data;

	stiff_string_rk4_step_top #(.POINTS(N_PTS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .point_index(point_index), .write_value(write_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_value(read_value), .saturated(saturated),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predicted string state and coefficients.
	int          disp_mem [N_PTS];
	int          vel_mem [N_PTS];
	int          trial_y [N_PTS];
	int          trial_v [N_PTS];
	int          sum_y [N_PTS];
	int          sum_v [N_PTS];
	int          k_y [N_PTS];
	int          k_v [N_PTS];
	bit          clip_seen;
	int unsigned wave_c, stiff_c, damp_c, dt_c;

	reply_t pending_replies[$];
	int     mismatches;
	int     replies_seen;
	int     requests_sent;
	int     steps_sent;
	bit     no_gaps;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Saturate to 32 bits; any clip is remembered for the current step.
	function automatic int clip32(longint x);
		if (x > 64'sd2147483647) begin
			clip_seen = 1'b1;
			return 32'sh7FFFFFFF;
		end
		if (x < -64'sd2147483648) begin
			clip_seen = 1'b1;
			return 32'sh80000000;
		end
		return int'(x);
	endfunction

	// Q8.24 product, rounded half up (arithmetic shift floors).
	function automatic longint scale(longint a, int unsigned c);
		longint p;
		p = a * longint'(c);
		return (p + (64'sd1 <<< 23)) >>> 24;
	endfunction

	function automatic longint ty(int i);
		if (i < 0 || i >= N_PTS) return 0;
		return longint'(trial_y[i]);
	endfunction

	function automatic longint tv(int i);
		if (i < 0 || i >= N_PTS) return 0;
		return longint'(trial_v[i]);
	endfunction

	function automatic longint div6_nearest(longint s);
		if (s >= 0) return (s + 3) / 6;
		return -((-s + 3) / 6);
	endfunction

	task automatic advance_string();
		longint acc, d2y, d4y, d2v, wgt, dy, dv;
		clip_seen = 1'b0;
		trial_y = disp_mem;
		trial_v = vel_mem;
		trial_y[0] = 0;
		trial_y[N_PTS-1] = 0;
		trial_v[0] = 0;
		trial_v[N_PTS-1] = 0;
		for (int s = 0; s < 4; s++) begin
			wgt = (s == 1 || s == 2) ? 2 : 1;
			for (int n = 1; n < N_PTS - 1; n++) begin
				d2y = clip32(ty(n+1) - 2*ty(n) + ty(n-1));
				d4y = clip32(ty(n+2) - 4*ty(n+1) + 6*ty(n) - 4*ty(n-1) + ty(n-2));
				d2v = clip32(tv(n+1) - 2*tv(n) + tv(n-1));
				acc = scale(d2y, wave_c) - scale(d4y, stiff_c) + scale(d2v, damp_c);
				k_v[n] = clip32(acc);
				k_y[n] = clip32(scale(tv(n), dt_c));
			end
			for (int n = 1; n < N_PTS - 1; n++) begin
				if (s == 0) begin
					sum_v[n] = k_v[n];
					sum_y[n] = k_y[n];
				end else begin
					sum_v[n] = clip32(longint'(sum_v[n]) + wgt * longint'(k_v[n]));
					sum_y[n] = clip32(longint'(sum_y[n]) + wgt * longint'(k_y[n]));
				end
				if (s < 3) begin
					dv = (s < 2) ? (longint'(k_v[n]) >>> 1) : longint'(k_v[n]);
					dy = (s < 2) ? (longint'(k_y[n]) >>> 1) : longint'(k_y[n]);
					trial_v[n] = clip32(longint'(vel_mem[n]) + dv);
					trial_y[n] = clip32(longint'(disp_mem[n]) + dy);
				end
			end
		end
		for (int n = 1; n < N_PTS - 1; n++) begin
			vel_mem[n] = clip32(longint'(vel_mem[n]) + div6_nearest(sum_v[n]));
			disp_mem[n] = clip32(longint'(disp_mem[n]) + div6_nearest(sum_y[n]));
		end
	endtask

	// Applies one accepted request to the predicted state and queues its reply.
	task automatic predict_request(action_t act, logic [7:0] idx, logic signed [31:0] val);
		reply_t r;
		r.value = '0;
		case (act)
			ACT_WRITE: begin
				if (idx >= 1 && idx < N_PTS - 1) begin
					disp_mem[idx] = val;
					vel_mem[idx] = 0;
				end
			end
			ACT_READ: begin
				r.value = disp_mem[idx];
			end
			ACT_STEP: begin
				advance_string();
				steps_sent++;
			end
			default: ;
		endcase
		r.clipped = clip_seen;
		pending_replies.push_back(r);
	endtask

	// Sends one request. It is entered right after the previous acceptance edge,
	// so valid is only lowered when a gap really follows.
	task automatic send_request(action_t act, logic [7:0] idx, logic signed [31:0] val);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		point_index <= idx;
		write_value <= val;
		do @(posedge clk); while (in_stall);
		predict_request(act, idx, val);
		requests_sent++;
	endtask

	// Holds back new requests until every reply has come, then lets the
	// block settle before anything is reconfigured.
	task automatic drain_replies();
		in_valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(logic [2:0] idx, logic [30:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_WAVE:  wave_c  = 32'(val);
			CFG_STIFF: stiff_c = 32'(val);
			CFG_DAMP:  damp_c  = 32'(val);
			CFG_STEP:  dt_c    = 32'(val);
			default: ;
		endcase
	endtask

	task automatic set_coefs(logic [30:0] w, logic [30:0] k, logic [30:0] d, logic [30:0] t);
		drain_replies();
		write_register(CFG_WAVE, w);
		write_register(CFG_STIFF, k);
		write_register(CFG_DAMP, d);
		write_register(CFG_STEP, t);
	endtask

	// Pinned ends and writes to them, the unused action and saturating steps.
	task automatic test_directed();
		send_request(ACT_READ, 8'd0, 32'sd0);
		send_request(ACT_READ, 8'd255, 32'sd0);
		send_request(ACT_WRITE, 8'd0, 32'sh7FFFFFFF);
		send_request(ACT_WRITE, 8'd255, 32'sh80000000);
		send_request(ACT_READ, 8'd0, 32'sd0);
		send_request(ACT_READ, 8'd255, 32'sd0);
		send_request(ACT_WRITE, 8'd1, 32'sh7FFFFFFF);
		send_request(ACT_WRITE, 8'd254, 32'sh80000000);
		send_request(ACT_WRITE, 8'd128, 32'sh01000000);
		send_request(ACT_WRITE, 8'd129, -32'sh01000000);
		send_request(ACT_READ, 8'd1, 32'sd0);
		send_request(ACT_READ, 8'd254, 32'sd0);
		send_request(ACT_NONE, 8'd77, 32'shFFFFFFFF);
		send_request(ACT_STEP, 8'd0, 32'sd0);
		send_request(ACT_READ, 8'd2, 32'sd0);
		send_request(ACT_READ, 8'd128, 32'sd0);
		send_request(ACT_NONE, 8'd1, 32'sd0);
		send_request(ACT_WRITE, 8'd1, 32'sd0);
		send_request(ACT_WRITE, 8'd254, 32'sd0);
		send_request(ACT_STEP, 8'd0, 32'sd0);
		send_request(ACT_READ, 8'd129, 32'sd0);
	endtask

	// Register extremes, including indexes past the list, which must be ignored.
	task automatic test_register_extremes();
		set_coefs('0, '0, '0, '0);
		write_register(3'd4, 31'h7FFFFFFF);
		write_register(3'd7, 31'h12345678);
		send_request(ACT_WRITE, 8'd100, 32'sh00800000);
		send_request(ACT_STEP, 8'd0, 32'sd0);
		send_request(ACT_READ, 8'd100, 32'sd0);
		set_coefs('1, '1, '1, '1);
		send_request(ACT_STEP, 8'd0, 32'sd0);
		send_request(ACT_READ, 8'd99, 32'sd0);
		send_request(ACT_STEP, 8'd0, 32'sd0);
		send_request(ACT_READ, 8'd100, 32'sd0);
	endtask

	// Random traffic: plausible shapes, some full-range noise, all if big_values.
	task automatic test_random(int count, bit big_values);
		action_t          act;
		logic signed [31:0] val;
		int unsigned      pick;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			act = (pick < 42) ? ACT_WRITE : (pick < 75) ? ACT_READ :
				(pick < 95) ? ACT_STEP : ACT_NONE;
			if (big_values || $urandom_range(0, 7) == 0)
				val = $urandom;
			else
				val = $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
			send_request(act, 8'($urandom_range(0, 255)), val);
		end
		no_gaps = 1'b0;
	endtask

	// Reply checker and receiver stall pattern.
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				replies_seen++;
				if (pending_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected reply: read_value=%0d saturated=%0b",
							read_value, saturated);
				end else begin
					want = pending_replies.pop_front();
					if (read_value !== want.value || saturated !== want.clipped) begin
						mismatches++;
						if (mismatches <= 10)
							$display("reply %0d mismatch: read_value exp %0d got %0d, saturated exp %0b got %0b",
								replies_seen, want.value, read_value, want.clipped, saturated);
					end
				end
				stall_left = no_gaps ? 0 : $urandom_range(0, 4);
			end
			out_stall <= (stall_left > 0);
			if (stall_left > 0) stall_left--;
		end
	end

	initial begin
		#40_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		action      = ACT_NONE;
		point_index = '0;
		write_value = '0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		mismatches  = 0;
		replies_seen = 0;
		requests_sent = 0;
		steps_sent  = 0;
		no_gaps     = 1'b0;
		clip_seen   = 1'b0;
		wave_c      = 67108864;
		stiff_c     = 16777;
		damp_c      = 1677722;
		dt_c        = 1678;
		for (int n = 0; n < N_PTS; n++) begin
			disp_mem[n] = 0;
			vel_mem[n]  = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random(200, 1'b0);
		test_register_extremes();
		set_coefs(31'($urandom), 31'($urandom_range(0, 1 << 20)),
			31'($urandom_range(0, 1 << 26)), 31'($urandom_range(0, 1 << 24)));
		test_random(170, 1'b0);
		set_coefs(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
		test_random(140, 1'b1);

		drain_replies();
		repeat (20) @(posedge clk);
		$display("Covered %0d requests (%0d RK4 steps) over five coefficient settings.",
			requests_sent, steps_sent);
		$display("%0d replies checked, %0d mismatches.", replies_seen, mismatches);
		if (mismatches == 0 && pending_replies.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
